[rtl/clst_pkg.sv]
// Package for the C-like source tokenizer: payload types, token kinds,
// lexer modes, the front/back request struct and character class helpers.
// No dependencies.
package clst_pkg;

    localparam int unsigned POSITION_BITS   = 16;
    localparam int unsigned KEYWORD_MAX_LEN = 9;
    localparam int unsigned Q_CNT_BITS      = 4;
    localparam int unsigned Q_DEPTH         = 8;
    localparam int unsigned Q_PTR_BITS      = 3;

    typedef logic [POSITION_BITS-1:0] t_cnt;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] value_start;
        logic [15:0] value_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_DOT, M_FRAC, M_IDENT, M_STR, M_ESC, M_OP, M_COMMENT
    } t_mode;

    localparam logic [5:0] K_INTLIT = 6'd0, K_FLOATLIT = 6'd1, K_STRLIT = 6'd2,
        K_IDENT = 6'd3, K_KW_INT = 6'd4, K_KW_FLOAT = 6'd5, K_KW_STRING = 6'd6,
        K_KW_VECTOR = 6'd7, K_KW_IF = 6'd8, K_KW_ELSE = 6'd9, K_KW_FOR = 6'd10,
        K_KW_WHILE = 6'd11, K_KW_VOID = 6'd12, K_KW_RETURN = 6'd13,
        K_KW_COUT = 6'd14, K_KW_CIN = 6'd15, K_KW_USING = 6'd16,
        K_KW_NAMESPACE = 6'd17, K_KW_STD = 6'd18,
        K_PLUS = 6'd19, K_MINUS = 6'd20, K_ARROW = 6'd21, K_STAR = 6'd22,
        K_SLASH = 6'd23, K_PERCENT = 6'd24, K_ASSIGN = 6'd25, K_EQ = 6'd26,
        K_NOT = 6'd27, K_NEQ = 6'd28, K_LT = 6'd29, K_LTE = 6'd30,
        K_LSHIFT = 6'd31, K_GT = 6'd32, K_GTE = 6'd33, K_RSHIFT = 6'd34,
        K_AND = 6'd35, K_OR = 6'd36, K_LPAREN = 6'd37, K_RPAREN = 6'd38,
        K_LBRACE = 6'd39, K_RBRACE = 6'd40, K_LBRACKET = 6'd41,
        K_RBRACKET = 6'd42, K_SEMI = 6'd43, K_COMMA = 6'd44, K_DOT = 6'd45,
        K_COLON = 6'd46, K_NEWLINE = 6'd47, K_EOF = 6'd48, K_ERROR = 6'd49;

    typedef struct packed {
        logic [5:0] kind;
        t_cnt       start;
        t_cnt       len;
        t_cnt       line;
        t_cnt       col;
    } t_tok;

    // one request: up to three tokens produced by one item
    typedef struct packed {
        logic [1:0] count;
        t_tok       tok0;
        t_tok       tok1;
        t_tok       tok2;
    } t_req;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha_u(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic is_opstart(input logic [7:0] c);
        return c == "-" || c == "=" || c == "!" || c == "<" || c == ">" ||
               c == "&" || c == "|" || c == "/";
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (&v) ? v : v + t_cnt'(1);
    endfunction

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [POSITION_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POSITION_BITS] ? {POSITION_BITS{1'b1}} : s[POSITION_BITS-1:0];
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "+": k = K_PLUS;
            "-": k = K_MINUS;
            "*": k = K_STAR;
            "/": k = K_SLASH;
            "%": k = K_PERCENT;
            "=": k = K_ASSIGN;
            "!": k = K_NOT;
            "<": k = K_LT;
            ">": k = K_GT;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "[": k = K_LBRACKET;
            "]": k = K_RBRACKET;
            ";": k = K_SEMI;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            ":": k = K_COLON;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        priority if (p == "-" && c == ">") k = K_ARROW;
        else if (p == "=" && c == "=") k = K_EQ;
        else if (p == "!" && c == "=") k = K_NEQ;
        else if (p == "<" && c == "=") k = K_LTE;
        else if (p == "<" && c == "<") k = K_LSHIFT;
        else if (p == ">" && c == "=") k = K_GTE;
        else if (p == ">" && c == ">") k = K_RSHIFT;
        else if (p == "&" && c == "&") k = K_AND;
        else if (p == "|" && c == "|") k = K_OR;
        else k = 6'd0;
        return k;
    endfunction

    function automatic logic [5:0] pending_single(input logic [7:0] p);
        return (p == "&" || p == "|") ? K_ERROR : single_kind(p);
    endfunction

    function automatic logic [8*KEYWORD_MAX_LEN-1:0] kw_pad(input logic [71:0] s);
        return (8*KEYWORD_MAX_LEN)'(s);
    endfunction

    // keyword match on length and zero-padded buffer (byte 0 in the low bits)
    function automatic logic [5:0] ident_kind(input t_cnt len,
                                              input logic [8*KEYWORD_MAX_LEN-1:0] b);
        logic [5:0] k;
        k = K_IDENT;
        priority if (len == t_cnt'(3) && b == kw_pad({48'd0, "tni"})) k = K_KW_INT;
        else if (len == t_cnt'(5) && b == kw_pad({32'd0, "taolf"})) k = K_KW_FLOAT;
        else if (len == t_cnt'(6) && b == kw_pad({24'd0, "gnirts"})) k = K_KW_STRING;
        else if (len == t_cnt'(6) && b == kw_pad({24'd0, "rotcev"})) k = K_KW_VECTOR;
        else if (len == t_cnt'(2) && b == kw_pad({56'd0, "fi"})) k = K_KW_IF;
        else if (len == t_cnt'(4) && b == kw_pad({40'd0, "esle"})) k = K_KW_ELSE;
        else if (len == t_cnt'(3) && b == kw_pad({48'd0, "rof"})) k = K_KW_FOR;
        else if (len == t_cnt'(5) && b == kw_pad({32'd0, "elihw"})) k = K_KW_WHILE;
        else if (len == t_cnt'(4) && b == kw_pad({40'd0, "diov"})) k = K_KW_VOID;
        else if (len == t_cnt'(6) && b == kw_pad({24'd0, "nruter"})) k = K_KW_RETURN;
        else if (len == t_cnt'(4) && b == kw_pad({40'd0, "tuoc"})) k = K_KW_COUT;
        else if (len == t_cnt'(3) && b == kw_pad({48'd0, "nic"})) k = K_KW_CIN;
        else if (len == t_cnt'(5) && b == kw_pad({32'd0, "gnisu"})) k = K_KW_USING;
        else if (len == t_cnt'(9) && b == kw_pad("ecapseman")) k = K_KW_NAMESPACE;
        else if (len == t_cnt'(3) && b == kw_pad({48'd0, "dts"})) k = K_KW_STD;
        else k = K_IDENT;
        return k;
    endfunction

endpackage

[rtl/clst_front.sv]
// Front end of the tokenizer: lexer state machine, one character per cycle while i_go
// and i_valid are high, forms a request of up to three tokens per item. Depends on clst_pkg.
module clst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  clst_pkg::t_in_item i_item,
    input  logic              i_go,
    output clst_pkg::t_req    o_req
);
    import clst_pkg::*;

    t_mode r_mode, n_mode;
    t_cnt r_pos, n_pos, r_line, n_line, r_col, n_col;
    t_cnt r_tstart, n_tstart, r_tlen, n_tlen, r_sline, n_sline, r_scol, n_scol;
    logic [8*KEYWORD_MAX_LEN-1:0] r_kw, n_kw;
    logic r_quote, n_quote;
    logic [7:0] r_pend, n_pend;

    logic [7:0] c;
    logic       fin;
    t_req       req;
    logic [7:0] quote;
    logic [5:0] pk;
    logic       restart;

    assign c     = i_item.ch;
    assign fin   = i_item.end_of_text || c == 8'd0;
    assign quote = r_quote ? 8'h27 : 8'h22;
    assign pk    = pair_kind(r_pend, c);

    always_comb begin
        t_cnt line_t, col_t, pos_t;
        t_tok t;
        logic do_start;
        n_mode = r_mode; n_pos = r_pos; n_line = r_line; n_col = r_col;
        n_tstart = r_tstart; n_tlen = r_tlen; n_sline = r_sline; n_scol = r_scol;
        n_kw = r_kw; n_quote = r_quote; n_pend = r_pend;
        req = '0;
        do_start = 1'b0;
        restart = 1'b0;
        line_t = r_line; col_t = r_col; pos_t = r_pos;
        t = '0;
        if (fin) begin
            restart = 1'b1;
            t.line = r_line; t.col = r_col;
            unique case (r_mode)
                M_INT: begin
                    t.kind = K_INTLIT; t.start = r_tstart; t.len = r_tlen;
                    req.tok0 = t; req.count = 2'd1;
                end
                M_FRAC: begin
                    t.kind = K_FLOATLIT; t.start = r_tstart; t.len = r_tlen;
                    req.tok0 = t; req.count = 2'd1;
                end
                M_DOT: begin
                    req.tok0 = '{K_INTLIT, r_tstart, r_tlen, r_sline, r_scol};
                    req.tok1 = '{K_DOT, sat_add(r_tstart, r_tlen), t_cnt'(1),
                                 r_line, r_col};
                    req.count = 2'd2;
                end
                M_IDENT: begin
                    req.tok0 = '{ident_kind(r_tlen, r_kw), r_tstart, r_tlen,
                                 r_line, r_col};
                    req.count = 2'd1;
                end
                M_STR, M_ESC: begin
                    req.tok0 = '{K_STRLIT, r_tstart, r_tlen, r_line, r_col};
                    req.count = 2'd1;
                end
                M_OP: begin
                    req.tok0 = '{pending_single(r_pend), r_tstart, t_cnt'(1),
                                 r_line, r_col};
                    req.count = 2'd1;
                end
                default: ;
            endcase
            t = '{K_EOF, '0, '0, r_line, r_col};
            unique case (req.count)
                2'd0: req.tok0 = t;
                2'd1: req.tok1 = t;
                default: req.tok2 = t;
            endcase
            req.count = req.count + 2'd1;
        end else begin
            unique case (r_mode)
                M_INT: begin
                    if (is_digit(c)) begin
                        n_tlen = sat_inc(r_tlen);
                    end else if (c == ".") begin
                        n_sline = r_line; n_scol = r_col; n_pend = c; n_mode = M_DOT;
                    end else begin
                        req.tok0 = '{K_INTLIT, r_tstart, r_tlen, r_line, r_col};
                        req.count = 2'd1; do_start = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        n_tlen = sat_add(r_tlen, t_cnt'(2)); n_mode = M_FRAC;
                    end else begin
                        req.tok0 = '{K_INTLIT, r_tstart, r_tlen, r_sline, r_scol};
                        req.tok1 = '{K_DOT, sat_add(r_tstart, r_tlen), t_cnt'(1),
                                     r_line, r_col};
                        req.count = 2'd2; do_start = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        n_tlen = sat_inc(r_tlen);
                    end else begin
                        req.tok0 = '{K_FLOATLIT, r_tstart, r_tlen, r_line, r_col};
                        req.count = 2'd1; do_start = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha_u(c) || is_digit(c)) begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                            if (r_tlen == t_cnt'(i)) n_kw[8*i +: 8] = c;
                        end
                        n_tlen = sat_inc(r_tlen);
                    end else begin
                        req.tok0 = '{ident_kind(r_tlen, r_kw), r_tstart, r_tlen,
                                     r_line, r_col};
                        req.count = 2'd1; do_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == quote) begin
                        req.tok0 = '{K_STRLIT, r_tstart, r_tlen, r_line, r_col};
                        req.count = 2'd1; n_mode = M_IDLE;
                    end else begin
                        if (c == 8'h5C) n_mode = M_ESC;
                        n_tlen = sat_inc(r_tlen);
                    end
                end
                M_ESC: begin
                    n_tlen = sat_inc(r_tlen); n_mode = M_STR;
                end
                M_OP: begin
                    if (pk != 6'd0) begin
                        req.tok0 = '{pk, r_tstart, t_cnt'(1), r_line, r_col};
                        req.count = 2'd1; n_mode = M_IDLE;
                    end else if (r_pend == "/" && c == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        req.tok0 = '{pending_single(r_pend), r_tstart, t_cnt'(1),
                                     r_line, r_col};
                        req.count = 2'd1; do_start = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == 8'h0A) do_start = 1'b1;
                end
                default: do_start = 1'b1;
            endcase
            // advance counters past c
            pos_t = sat_inc(r_pos);
            if (c == 8'h0A) begin
                line_t = sat_inc(r_line); col_t = '0;
            end else begin
                col_t = sat_inc(r_col);
            end
            n_pos = pos_t; n_line = line_t; n_col = col_t;
            if (do_start) begin
                n_mode = M_IDLE;
                t = '0;
                t.line = line_t; t.col = col_t;
                if (is_blank(c)) begin
                    t = '0;
                end else if (c == 8'h0A) begin
                    t.kind = K_NEWLINE;
                end else if (is_digit(c)) begin
                    n_tstart = r_pos; n_tlen = t_cnt'(1); n_mode = M_INT;
                end else if (c == 8'h22 || c == 8'h27) begin
                    n_quote = (c == 8'h27); n_tstart = pos_t; n_tlen = '0;
                    n_mode = M_STR;
                end else if (is_alpha_u(c)) begin
                    n_kw = '0; n_kw[7:0] = c; n_tstart = r_pos; n_tlen = t_cnt'(1);
                    n_mode = M_IDENT;
                end else if (is_opstart(c)) begin
                    n_tstart = r_pos; n_pend = c; n_mode = M_OP;
                end else begin
                    t.kind = single_kind(c); t.start = r_pos; t.len = t_cnt'(1);
                end
                if (!is_blank(c) && (c == 8'h0A || !(is_digit(c) || c == 8'h22 ||
                    c == 8'h27 || is_alpha_u(c) || is_opstart(c)))) begin
                    if (req.count == 2'd0) req.tok0 = t;
                    else if (req.count == 2'd1) req.tok1 = t;
                    else req.tok2 = t;
                    req.count = req.count + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && restart && i_valid)) begin
            r_mode <= M_IDLE; r_pos <= '0; r_line <= t_cnt'(1); r_col <= '0;
            r_tstart <= '0; r_tlen <= '0; r_kw <= '0; r_quote <= 1'b0;
            r_pend <= '0; r_sline <= t_cnt'(1); r_scol <= '0;
        end else if (i_go && i_valid) begin
            r_mode <= n_mode; r_pos <= n_pos; r_line <= n_line; r_col <= n_col;
            r_tstart <= n_tstart; r_tlen <= n_tlen; r_kw <= n_kw;
            r_quote <= n_quote; r_pend <= n_pend; r_sline <= n_sline;
            r_scol <= n_scol;
        end
    end

    assign o_req = req;
endmodule

[rtl/clst_back.sv]
// Back end: token queue fed by front requests, drains one token per cycle while
// i_stall is low to the output channel and marks the last token of each item.
// Depends on clst_pkg.
module clst_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  clst_pkg::t_req     i_req,
    output logic               o_room,
    output logic               o_valid,
    output clst_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import clst_pkg::*;

    typedef struct packed {
        t_tok tok;
        logic last;
    } t_ent;

    t_ent r_q [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_rd, r_wr;
    logic [Q_CNT_BITS-1:0] r_cnt, n_cnt;
    logic       pop;
    t_ent       head;

    assign head    = r_q[r_rd];
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;
    assign o_room  = r_cnt <= Q_CNT_BITS'(Q_DEPTH - 3);
    assign n_cnt   = r_cnt + (i_push ? {{(Q_CNT_BITS-2){1'b0}}, i_req.count} : '0)
                     - {{(Q_CNT_BITS-1){1'b0}}, pop};

    assign o_item.token_kind    = head.tok.kind;
    assign o_item.value_start   = 16'(head.tok.start);
    assign o_item.value_length  = 16'(head.tok.len);
    assign o_item.line_number   = 16'(head.tok.line);
    assign o_item.column_number = 16'(head.tok.col);
    assign o_item.last_of_run   = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            if (pop) r_rd <= r_rd + Q_PTR_BITS'(1);
            if (i_push) r_wr <= r_wr + Q_PTR_BITS'(i_req.count);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_req.count >= 2'd1)
                r_q[r_wr] <= '{i_req.tok0, i_req.count == 2'd1};
            if (i_req.count >= 2'd2)
                r_q[r_wr + Q_PTR_BITS'(1)] <= '{i_req.tok1, i_req.count == 2'd2};
            if (i_req.count == 2'd3)
                r_q[r_wr + Q_PTR_BITS'(2)] <= '{i_req.tok2, 1'b1};
        end
    end
endmodule

[rtl/c_like_source_tokenizer_unit.sv]
// Top level of the C-like source tokenizer: lexer front end and token queue
// back end. Depends on clst_pkg, clst_front, clst_back.
//
//  channel | direction | payload    | handshake
//  in      | input     | t_in_item  | i_valid / o_stall
//  out     | output    | t_out_item | o_valid / i_stall
//
// One byte is accepted per cycle; its tokens (up to three) enter the queue in
// the same cycle and leave one per cycle while i_stall is low, set by the single output port.
// The input stalls only while the eight-entry queue has fewer than three free
// slots. Reset is synchronous; an EOF item returns the lexer to reset state.
module c_like_source_tokenizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  clst_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output clst_pkg::t_out_item o_item
);
    import clst_pkg::*;

    t_req req;
    logic room;
    logic push;

    assign o_stall = !room;
    assign push    = i_valid && room;

    clst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_item),
        .i_go(room), .o_req(req)
    );

    clst_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(req),
        .o_room(room), .o_valid(o_valid), .o_item(o_item), .i_stall(i_stall)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("output dropped under stall");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.token_kind == K_EOF |-> o_item.last_of_run)
        else $error("EOF not last of run");
    a_push_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (i_item.end_of_text || i_item.ch == 8'd0) |-> req.count != 2'd0)
        else $error("end item without tokens");
endmodule

[verif/tb_c_like_source_tokenizer_unit.sv]
// Testbench for c_like_source_tokenizer_unit: drives source bytes, predicts
// tokens with a behavioral lexer and checks every token in order.
// Depends on clst_pkg and the tokenizer RTL.
module tb_c_like_source_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import clst_pkg::*;

    class token_scoreboard;
        t_out_item pending_tokens[$];
        int errors;
        t_mode mode;
        logic [15:0] pos, line, col, tstart, tlen, sline, scol;
        logic [7:0] kw[KEYWORD_MAX_LEN];
        logic sq;
        logic [7:0] pend;
        t_out_item step_toks[$];

        function void clear();
            mode = M_IDLE; pos = 0; line = 1; col = 0; tstart = 0; tlen = 0;
            foreach (kw[i]) kw[i] = 0;
            sq = 0; pend = 0; sline = 1; scol = 0;
        endfunction

        function void put(logic [5:0] k, logic [15:0] s, logic [15:0] l,
                          logic [15:0] ln, logic [15:0] cl);
            t_out_item t;
            t.token_kind = k; t.value_start = s; t.value_length = l;
            t.line_number = ln; t.column_number = cl; t.last_of_run = 0;
            step_toks.push_back(t);
        endfunction

        function void advance(logic [7:0] c);
            pos = sat_inc(pos);
            if (c == 8'h0A) begin
                line = sat_inc(line);
                col = 0;
            end else begin
                col = sat_inc(col);
            end
        endfunction

        function logic [5:0] word_kind();
            string w;
            logic [5:0] k;
            w = "";
            for (int i = 0; i < KEYWORD_MAX_LEN && i < tlen; i++) w = {w, string'(kw[i])};
            k = K_IDENT;
            case (w)
                "int": k = K_KW_INT;
                "float": k = K_KW_FLOAT;
                "string": k = K_KW_STRING;
                "vector": k = K_KW_VECTOR;
                "if": k = K_KW_IF;
                "else": k = K_KW_ELSE;
                "for": k = K_KW_FOR;
                "while": k = K_KW_WHILE;
                "void": k = K_KW_VOID;
                "return": k = K_KW_RETURN;
                "cout": k = K_KW_COUT;
                "cin": k = K_KW_CIN;
                "using": k = K_KW_USING;
                "namespace": k = K_KW_NAMESPACE;
                "std": k = K_KW_STD;
                default: k = K_IDENT;
            endcase
            if (tlen > KEYWORD_MAX_LEN) k = K_IDENT;
            return k;
        endfunction

        function logic [5:0] one_char(logic [7:0] c);
            case (c)
                "+": return K_PLUS;
                "-": return K_MINUS;
                "*": return K_STAR;
                "/": return K_SLASH;
                "%": return K_PERCENT;
                "=": return K_ASSIGN;
                "!": return K_NOT;
                "<": return K_LT;
                ">": return K_GT;
                "(": return K_LPAREN;
                ")": return K_RPAREN;
                "{": return K_LBRACE;
                "}": return K_RBRACE;
                "[": return K_LBRACKET;
                "]": return K_RBRACKET;
                ";": return K_SEMI;
                ",": return K_COMMA;
                ".": return K_DOT;
                ":": return K_COLON;
                default: return K_ERROR;
            endcase
        endfunction

        function logic [5:0] op_pair(logic [7:0] p, logic [7:0] c);
            if (p == "-" && c == ">") return K_ARROW;
            if (p == "=" && c == "=") return K_EQ;
            if (p == "!" && c == "=") return K_NEQ;
            if (p == "<" && c == "=") return K_LTE;
            if (p == "<" && c == "<") return K_LSHIFT;
            if (p == ">" && c == "=") return K_GTE;
            if (p == ">" && c == ">") return K_RSHIFT;
            if (p == "&" && c == "&") return K_AND;
            if (p == "|" && c == "|") return K_OR;
            return 0;
        endfunction

        function logic [5:0] lone_op();
            return (pend == "&" || pend == "|") ? K_ERROR : one_char(pend);
        endfunction

        function void begin_token(logic [7:0] c);
            logic [15:0] at;
            mode = M_IDLE;
            if (c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
                advance(c);
            end else if (c == 8'h0A) begin
                advance(c);
                put(K_NEWLINE, 0, 0, line, col);
            end else if (c >= "0" && c <= "9") begin
                tstart = pos; tlen = 1; advance(c); mode = M_INT;
            end else if (c == "\"" || c == "'") begin
                sq = (c == "'"); advance(c); tstart = pos; tlen = 0; mode = M_STR;
            end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
                foreach (kw[i]) kw[i] = 0;
                kw[0] = c; tstart = pos; tlen = 1; advance(c); mode = M_IDENT;
            end else if (c inside {"-", "=", "!", "<", ">", "&", "|", "/"}) begin
                tstart = pos; pend = c; advance(c); mode = M_OP;
            end else begin
                at = pos; advance(c);
                put(one_char(c), at, 1, line, col);
            end
        endfunction

        function void note_request(t_in_item it);
            logic [7:0] c;
            logic [5:0] pk;
            logic is_dig, is_word;
            c = it.ch;
            step_toks.delete();
            is_dig = c >= "0" && c <= "9";
            is_word = is_dig || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
            if (it.end_of_text || c == 0) begin
                case (mode)
                    M_INT: put(K_INTLIT, tstart, tlen, line, col);
                    M_FRAC: put(K_FLOATLIT, tstart, tlen, line, col);
                    M_DOT: begin
                        put(K_INTLIT, tstart, tlen, sline, scol);
                        put(K_DOT, sat_add(tstart, tlen), 1, line, col);
                    end
                    M_IDENT: put(word_kind(), tstart, tlen, line, col);
                    M_STR, M_ESC: put(K_STRLIT, tstart, tlen, line, col);
                    M_OP: put(lone_op(), tstart, 1, line, col);
                    default: ;
                endcase
                put(K_EOF, 0, 0, line, col);
                clear();
            end else begin
                case (mode)
                    M_INT:
                        if (is_dig) begin
                            tlen = sat_inc(tlen); advance(c);
                        end else if (c == ".") begin
                            sline = line; scol = col; pend = c; advance(c); mode = M_DOT;
                        end else begin
                            put(K_INTLIT, tstart, tlen, line, col); begin_token(c);
                        end
                    M_DOT:
                        if (is_dig) begin
                            tlen = sat_add(tlen, 2); advance(c); mode = M_FRAC;
                        end else begin
                            put(K_INTLIT, tstart, tlen, sline, scol);
                            put(K_DOT, sat_add(tstart, tlen), 1, line, col);
                            begin_token(c);
                        end
                    M_FRAC:
                        if (is_dig) begin
                            tlen = sat_inc(tlen); advance(c);
                        end else begin
                            put(K_FLOATLIT, tstart, tlen, line, col); begin_token(c);
                        end
                    M_IDENT:
                        if (is_word) begin
                            if (tlen < KEYWORD_MAX_LEN) kw[tlen] = c;
                            tlen = sat_inc(tlen); advance(c);
                        end else begin
                            put(word_kind(), tstart, tlen, line, col); begin_token(c);
                        end
                    M_STR:
                        if (c == (sq ? 8'h27 : 8'h22)) begin
                            put(K_STRLIT, tstart, tlen, line, col); advance(c); mode = M_IDLE;
                        end else begin
                            if (c == 8'h5C) mode = M_ESC;
                            tlen = sat_inc(tlen); advance(c);
                        end
                    M_ESC: begin
                        tlen = sat_inc(tlen); advance(c); mode = M_STR;
                    end
                    M_OP: begin
                        pk = op_pair(pend, c);
                        if (pk != 0) begin
                            put(pk, tstart, 1, line, col); advance(c); mode = M_IDLE;
                        end else if (pend == "/" && c == "/") begin
                            advance(c); mode = M_COMMENT;
                        end else begin
                            put(lone_op(), tstart, 1, line, col); begin_token(c);
                        end
                    end
                    M_COMMENT:
                        if (c == 8'h0A) begin_token(c);
                        else advance(c);
                    default: begin_token(c);
                endcase
            end
            if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1;
            foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
        endfunction

        function void check_token(t_out_item got);
            t_out_item exp;
            if (pending_tokens.size() == 0) begin
                $error("unexpected token kind %0d", got.token_kind);
                errors++;
                return;
            end
            exp = pending_tokens.pop_front();
            if (got.token_kind !== exp.token_kind) begin
                $error("token_kind exp %0d got %0d", exp.token_kind, got.token_kind); errors++;
            end
            if (got.value_start !== exp.value_start) begin
                $error("value_start exp %0d got %0d", exp.value_start, got.value_start);
                errors++;
            end
            if (got.value_length !== exp.value_length) begin
                $error("value_length exp %0d got %0d", exp.value_length, got.value_length);
                errors++;
            end
            if (got.line_number !== exp.line_number) begin
                $error("line_number exp %0d got %0d", exp.line_number, got.line_number);
                errors++;
            end
            if (got.column_number !== exp.column_number) begin
                $error("column_number exp %0d got %0d", exp.column_number, got.column_number);
                errors++;
            end
            if (got.last_of_run !== exp.last_of_run) begin
                $error("last_of_run exp %0d got %0d", exp.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic o_stall, o_valid;
    t_in_item i_item = '0;
    t_out_item o_item;
    int send_idle_pct = 0, recv_idle_pct = 0;
    token_scoreboard sb = new();

    c_like_source_tokenizer_unit dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_token(o_item);
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_byte(logic [7:0] c, logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item <= '{ch: c, end_of_text: eot};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request('{ch: c, end_of_text: eot});
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    function automatic string random_lexeme();
        string w[] = '{"int", "float", "string", "vector", "if", "else", "for", "while",
            "void", "return", "cout", "cin", "using", "namespace", "std", "x_9", "Zq",
            "namespaces", "abcdefghijkl", "12", "3.75", "7.", "0", "\"a\\\"b\"", "'q\\'",
            "+", "-", "->", "*", "/", "%", "=", "==", "!", "!=", "<", "<=", "<<", ">",
            ">=", ">>", "&&", "||", "&", "|", "(", ")", "{", "}", "[", "]", ";", ",",
            ".", ":", "// note\n", "\n", " ", "\t", "\x0D", "@", "#", "\"open"};
        return w[$urandom_range(w.size()-1)];
    endfunction

    task automatic random_phase(int n);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) == 0) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1))); k++;
            end else begin
                string s;
                s = random_lexeme();
                send_text(s); k += s.len();
                if ($urandom_range(2) == 0) begin
                    send_byte(" ", 1'b0); k++;
                end
            end
            if ($urandom_range(30) == 0) begin
                send_byte(8'($urandom_range(255)), 1'b1); k++;
            end
        end
        send_byte(8'h00, 1'b1);
    endtask

    initial begin
        sb.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_text("int x=3.5;a->b!=c<=d\n7.e 'x\\'y' \"s\"&|/");
        send_text("/ c\n\x80\xFF9.");
        send_byte(8'h55, 1'b1);
        send_text("\"ab\\");
        send_byte(8'h00, 1'b0);
        send_idle_pct = 13; recv_idle_pct = 52;
        random_phase(70);
        send_idle_pct = 52; recv_idle_pct = 13;
        random_phase(70);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(70);
        i_valid <= 0;
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("c_like_source_tokenizer_unit: match");
        else $display("c_like_source_tokenizer_unit: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("c_like_source_tokenizer_unit: mismatch");
        $finish;
    end
endmodule
